FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the merge sorter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/msort_pkg.sv
// Types and constants shared by the merge sorter modules.
package msort_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 16;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_set;
    logic                     overflow;
  } out_item_t;

  // Status from the merge sequencer to the top level.
  typedef struct packed {
    logic done;
    logic src_sel;
  } merge_stat_t;

endpackage

FILE: hw/rtl/msort_ram.sv
// Generic RAM with one write port and two registered read ports.
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: hw/rtl/msort_merge.sv
// Bottom-up merge sequencer with one shared signed comparator.
module msort_merge #(
  parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]      n_i,
  input  logic signed [msort_pkg::DATA_W-1:0] va_i,
  input  logic signed [msort_pkg::DATA_W-1:0] vb_i,
  output logic [$clog2(MAX_ITEMS)-1:0]        rd_a_o,
  output logic [$clog2(MAX_ITEMS)-1:0]        rd_b_o,
  output logic                                we_o,
  output logic [$clog2(MAX_ITEMS)-1:0]        waddr_o,
  output logic [msort_pkg::DATA_W-1:0]        wdata_o,
  output msort_pkg::merge_stat_t              stat_o
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 2;

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_SETUP = 4'b0010,
    M_MERGE = 4'b0100,
    M_DONE  = 4'b1000
  } mstate_e;

  mstate_e       state_q, state_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW:0]   width_q, width_d;
  logic [CW-1:0] lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [CW-1:0] a_q, a_d, b_q, b_d, k_q, k_d;
  logic          parity_q, parity_d;

  logic [SW-1:0] sum_mid, sum_hi;
  logic [CW-1:0] mid_c, hi_c;
  logic          a_more, b_more, take_a, k_last;

  // Run bounds of the pair that starts at lo, clipped to the set size.
  assign sum_mid = SW'(lo_q) + SW'(width_q);
  assign sum_hi  = SW'(lo_q) + {width_q, 1'b0};
  assign mid_c   = (sum_mid > SW'(n_q)) ? n_q : sum_mid[CW-1:0];
  assign hi_c    = (sum_hi > SW'(n_q)) ? n_q : sum_hi[CW-1:0];

  assign a_more = a_q < mid_q;
  assign b_more = b_q < hi_q;
  assign take_a = a_more && (!b_more || (va_i < vb_i));
  assign k_last = ({1'b0, k_q} + (CW+1)'(1)) == {1'b0, hi_q};

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    width_d  = width_q;
    lo_d     = lo_q;
    mid_d    = mid_q;
    hi_d     = hi_q;
    a_d      = a_q;
    b_d      = b_q;
    k_d      = k_q;
    parity_d = parity_q;
    unique case (state_q)
      M_IDLE: begin
        if (start_i) begin
          n_d      = n_i;
          width_d  = (CW+1)'(1);
          lo_d     = '0;
          parity_d = 1'b0;
          state_d  = (n_i <= CW'(1)) ? M_DONE : M_SETUP;
        end
      end
      M_SETUP: begin
        mid_d   = mid_c;
        hi_d    = hi_c;
        a_d     = lo_q;
        b_d     = mid_c;
        k_d     = lo_q;
        state_d = M_MERGE;
      end
      M_MERGE: begin
        if (take_a) begin
          a_d = a_q + CW'(1);
        end else begin
          b_d = b_q + CW'(1);
        end
        k_d = k_q + CW'(1);
        if (k_last) begin
          lo_d    = hi_q;
          state_d = M_SETUP;
          if (hi_q == n_q) begin
            // End of a pass: the runs double and the buffers swap roles.
            width_d  = {width_q[CW-1:0], 1'b0};
            lo_d     = '0;
            parity_d = ~parity_q;
            if ({width_q, 1'b0} >= SW'(n_q)) begin
              state_d = M_DONE;
            end
          end
        end
      end
      M_DONE: begin
        state_d = M_IDLE;
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= M_IDLE;
      parity_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      parity_q <= parity_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    width_q <= width_d;
    lo_q    <= lo_d;
    mid_q   <= mid_d;
    hi_q    <= hi_d;
    a_q     <= a_d;
    b_q     <= b_d;
    k_q     <= k_d;
  end

  // Read addresses follow the next pointers so the registered data matches a_q and b_q.
  assign rd_a_o  = a_d[IW-1:0];
  assign rd_b_o  = b_d[IW-1:0];
  assign we_o    = (state_q == M_MERGE);
  assign waddr_o = k_q[IW-1:0];
  assign wdata_o = take_a ? va_i : vb_i;

  assign stat_o.done    = (state_q == M_DONE);
  assign stat_o.src_sel = parity_q;

endmodule

FILE: hw/rtl/merge_sorter_top.sv
// Merge sorter top level: set loading, sort sequencing and result output.
//
// Input items (value, is_last) arrive on a valid/stall channel. Each accepted
// value is written to the store; the item with is_last ends the set. Items
// beyond MAX_ITEMS are dropped and mark every result of that set as overflow.
// After the last item the block stalls its input while it sorts and outputs:
// a bottom-up merge over two ping-pong buffers, one compared and written
// value per cycle in the merge state, with ceil(log2 n) passes, a setup
// state before each run pair and a closing done state. The sorted values
// then leave on the output channel, smallest first, each passing a read
// state and then a load state; end_of_set marks the last one.
// The result sits in an output register; when the receiver stalls, the
// output phase waits and nothing is lost. The next set may start loading
// while the final result of the previous one still waits to be taken.
// Reset empties the store count, clears the overflow flag and the output
// valid flag; stored values and the output data are not cleared.
`include "assert_macros.svh"

module merge_sorter_top #(
  parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  msort_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output msort_pkg::out_item_t out_item_o
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int DW = msort_pkg::DATA_W;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SORT    = 4'b0010,
    ST_EMIT_RD = 4'b0100,
    ST_EMIT_WR = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        k_q, k_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  msort_pkg::out_item_t out_q, out_d;

  logic                   accept, room, load_we, start, slot_free;
  logic [CW-1:0]          count_inc;
  logic [IW-1:0]          m_rd_a, m_rd_b, m_waddr, rd_a;
  logic                   m_we;
  logic [DW-1:0]          m_wdata;
  msort_pkg::merge_stat_t mstat;

  logic          we0, we1;
  logic [IW-1:0] waddr0;
  logic [DW-1:0] wdata0;
  logic [DW-1:0] r0a, r0b, r1a, r1b;
  logic signed [DW-1:0] va, vb;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign room       = count_q < CW'(MAX_ITEMS);
  assign load_we    = accept && room;
  assign count_inc  = room ? count_q + CW'(1) : count_q;
  assign start      = accept && in_item_i.is_last;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          count_d = count_inc;
          if (!room) begin
            ovf_d = 1'b1;
          end
          if (in_item_i.is_last) begin
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (mstat.done) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.sorted_value = va;
          out_d.end_of_set   = (k_q + CW'(1)) == count_q;
          out_d.overflow     = ovf_q;
          k_d                = k_q + CW'(1);
          if ((k_q + CW'(1)) == count_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  msort_merge #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .n_i     (count_inc),
    .va_i    (va),
    .vb_i    (vb),
    .rd_a_o  (m_rd_a),
    .rd_b_o  (m_rd_b),
    .we_o    (m_we),
    .waddr_o (m_waddr),
    .wdata_o (m_wdata),
    .stat_o  (mstat)
  );

  // Buffer 0 takes the loaded set; each pass writes the buffer it does not read.
  assign we0    = load_we || (m_we && mstat.src_sel);
  assign we1    = m_we && !mstat.src_sel;
  assign waddr0 = load_we ? count_q[IW-1:0] : m_waddr;
  assign wdata0 = load_we ? in_item_i.value : m_wdata;
  assign rd_a   = (state_q == ST_SORT) ? m_rd_a : k_q[IW-1:0];

  msort_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_ITEMS)
  ) u_buf0 (
    .clk_i     (clk_i),
    .we_i      (we0),
    .waddr_i   (waddr0),
    .wdata_i   (wdata0),
    .raddr_a_i (rd_a),
    .raddr_b_i (m_rd_b),
    .rdata_a_o (r0a),
    .rdata_b_o (r0b)
  );

  msort_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_ITEMS)
  ) u_buf1 (
    .clk_i     (clk_i),
    .we_i      (we1),
    .waddr_i   (m_waddr),
    .wdata_i   (m_wdata),
    .raddr_a_i (rd_a),
    .raddr_b_i (m_rd_b),
    .rdata_a_o (r1a),
    .rdata_b_o (r1b)
  );

  // After the last pass src_sel names the buffer that holds the sorted set.
  assign va = mstat.src_sel ? r1a : r0a;
  assign vb = mstat.src_sel ? r1b : r0b;

  `ASSERT_CLKD(a_count_bound, clk_i, rst_ni, count_q <= CW'(MAX_ITEMS), "store count above capacity")
  `ASSERT_IMPL(a_done_in_sort, clk_i, rst_ni, mstat.done, state_q == ST_SORT, "merge done outside sort")
  `ASSERT_IMPL(a_emit_index, clk_i, rst_ni, (state_q == ST_EMIT_RD) || (state_q == ST_EMIT_WR), k_q < count_q, "output index past set size")
  `ASSERT_IMPL(a_result_src, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_EMIT_WR), "result loaded outside output phase")

endmodule

FILE: verif/tb_merge_sorter_top.sv
// Self-checking testbench for the merge sorter top level.
module tb_merge_sorter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = msort_pkg::DATA_W;
  localparam int SET_CAP = msort_pkg::MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTS = 60;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef msort_pkg::in_item_t  in_item_t;
  typedef msort_pkg::out_item_t out_item_t;

  typedef enum int {
    PH_SLOW_RX,
    PH_SLOW_TX,
    PH_FULL_RATE
  } pace_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Items waiting to be offered and sorted values still owed by the block.
  in_item_t  feed_q[$];
  out_item_t sorted_due_q[$];

  // Shadow copy of the set being loaded.
  logic signed [DATA_W-1:0] shadow_store[SET_CAP];
  int        shadow_fill = 0;
  logic      shadow_dropped = 1'b0;

  int        err_cnt = 0;
  int        offered_cnt = 0;
  pace_e     pace = PH_SLOW_RX;
  logic      in_taken = 1'b0;
  logic      hold_off = 1'b0;

  merge_sorter_top #(
    .MAX_ITEMS(SET_CAP)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  // Load one value into the shadow set; on the last item emit the set in order.
  task automatic take_value(input in_item_t it);
    logic signed [DATA_W-1:0] key;
    out_item_t r;
    int j;
    if (shadow_fill < SET_CAP) begin
      shadow_store[shadow_fill] = it.value;
      shadow_fill++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (it.is_last) begin
      for (int i = 1; i < shadow_fill; i++) begin
        key = shadow_store[i];
        j = i - 1;
        while (j >= 0 && shadow_store[j] > key) begin
          shadow_store[j + 1] = shadow_store[j];
          j--;
        end
        shadow_store[j + 1] = key;
      end
      for (int i = 0; i < shadow_fill; i++) begin
        r.sorted_value = shadow_store[i];
        r.end_of_set   = (i == shadow_fill - 1);
        r.overflow     = shadow_dropped;
        sorted_due_q.push_back(r);
      end
      shadow_fill    = 0;
      shadow_dropped = 1'b0;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = VAL_MIN;
      1: v = VAL_MAX;
      2, 3: v = $signed($urandom_range(15)) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // A set of n items; only the final one carries is_last.
  task automatic queue_set(input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.value   = pick_value();
      it.is_last = (i == n - 1);
      feed_q.push_back(it);
    end
  endtask

  task automatic queue_item(input logic signed [DATA_W-1:0] v, input logic last);
    in_item_t it;
    it.value   = v;
    it.is_last = last;
    feed_q.push_back(it);
  endtask

  // Sender: a new item goes out only when the line is free or was just taken.
  always @(negedge clk_i) begin
    int tx_idle;
    tx_idle = (pace == PH_SLOW_RX) ? 22 : (pace == PH_SLOW_TX) ? 80 : 0;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (feed_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
        in_item_i  <= feed_q.pop_front();
        in_valid_i <= 1'b1;
        offered_cnt++;
        if (offered_cnt >= 360) begin
          pace = PH_FULL_RATE;
        end else if (offered_cnt >= 200) begin
          pace = PH_SLOW_TX;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern.
  always @(negedge clk_i) begin
    int rx_idle;
    rx_idle = (pace == PH_SLOW_RX) ? 80 : (pace == PH_SLOW_TX) ? 22 : 0;
    out_stall_i <= hold_off || ($urandom_range(99) < rx_idle);
  end

  // Monitor: check results against the oldest owed value, then absorb inputs.
  always @(posedge clk_i) begin
    out_item_t due;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (sorted_due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected item value %0d", out_item_o.sorted_value));
        end else begin
          due = sorted_due_q.pop_front();
          if (out_item_o.sorted_value !== due.sorted_value) begin
            flag_mismatch($sformatf("sorted_value %0d, expected %0d",
                                    out_item_o.sorted_value, due.sorted_value));
          end
          if (out_item_o.end_of_set !== due.end_of_set) begin
            flag_mismatch($sformatf("end_of_set %b, expected %b",
                                    out_item_o.end_of_set, due.end_of_set));
          end
          if (out_item_o.overflow !== due.overflow) begin
            flag_mismatch($sformatf("overflow %b, expected %b",
                                    out_item_o.overflow, due.overflow));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        take_value(in_item_i);
      end
    end
  end

  // Once full rate begins, the receiver stops for a long while so the block backs up.
  initial begin
    while (pace != PH_FULL_RATE) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int rand_cnt;
    int n;
    // Lone item, the field extremes, and equal values.
    queue_item(VAL_MAX, 1'b1);
    queue_item(VAL_MIN, 1'b0);
    queue_item(VAL_MAX, 1'b0);
    queue_item(0, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(1, 1'b1);
    queue_item(7, 1'b0);
    queue_item(7, 1'b0);
    queue_item(-7, 1'b1);
    // Full store, then the last-marked item is dropped as well.
    for (int i = 0; i < SET_CAP; i++) begin
      queue_item(SET_CAP - i, 1'b0);
    end
    queue_item(VAL_MIN, 1'b1);

    rand_cnt = 0;
    while (rand_cnt < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: n = SET_CAP + 1 + $urandom_range(3);
        1: n = SET_CAP;
        2: n = 1;
        default: n = 2 + $urandom_range(SET_CAP - 3);
      endcase
      queue_set(n);
      rand_cnt += n;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (feed_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (sorted_due_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
